// ===== src/kmst_pkg.sv =====
// Shared types for the Kruskal spanning tree block.
`default_nettype none
package kmst_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_DECIDE,
      ST_PUSH,
      ST_FINAL
   } kmst_state_type;

   localparam int WEIGHT_W = 16;
   localparam int VCOUNT_W = 6;
   localparam int DROP_W = 6;
   localparam int KIND_RUN = 1;

endpackage
`default_nettype wire

// ===== src/kmst_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module kmst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== src/kruskal_minimum_spanning_tree_top.sv =====
// Kruskal minimum spanning forest: edge loading, sorted selection, union-find and result output.
// Edge items (kind 0) are taken one per cycle and stored in an edge RAM. A run item (kind 1)
// first initializes the root-link RAM, one vertex a cycle. Then, for each edge in ascending
// (weight, from, to) order, it scans the whole edge RAM to find the next smallest key and
// walks the root links of both ends, with a read state and a check state per vertex visited.
// A decision state and, for a tree edge, a push state follow each walk. Duplicate edges are
// skipped by the strictly-greater selection. Each tree edge is held for one step so that the
// final one can carry is_last; a run with no tree edge gives one empty result. Input items
// are not accepted during a run.
`default_nettype none
module kruskal_minimum_spanning_tree_top #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [kmst_pkg::VCOUNT_W-1:0]   csr_write_data,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_kind,
   input  wire logic [$clog2(MAX_VERTICES)-1:0] req_from_vertex,
   input  wire logic [$clog2(MAX_VERTICES)-1:0] req_to_vertex,
   input  wire logic signed [kmst_pkg::WEIGHT_W-1:0] req_edge_weight,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [$clog2(MAX_VERTICES)-1:0] rsp_tree_from,
   output logic      [$clog2(MAX_VERTICES)-1:0] rsp_tree_to,
   output logic signed [kmst_pkg::WEIGHT_W-1:0] rsp_tree_weight,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_last,
   output logic      [kmst_pkg::DROP_W-1:0]     rsp_dropped_count
);
   import kmst_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int EW = $clog2(MAX_EDGES);
   localparam int KW = WEIGHT_W + 2 * VW;
   localparam int CW = (VW > VCOUNT_W ? VW : VCOUNT_W) + 2;

   kmst_state_type state_ff, state_in;

   logic [VCOUNT_W-1:0] vcount_ff, vcount_in;
   logic [EW:0]         total_ff, total_in;
   logic [DROP_W-1:0]   drop_ff, drop_in;
   logic [VW-1:0]       init_idx_ff, init_idx_in;
   logic [EW:0]         scan_idx_ff, scan_idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                found_ff, found_in;
   logic [KW-1:0]       best_ff, best_in;
   logic                have_prev_ff, have_prev_in;
   logic [KW-1:0]       prev_ff, prev_in;
   logic [VW-1:0]       walk_v_ff, walk_v_in;
   logic                side_ff, side_in;
   logic [VW-1:0]       root_a_ff, root_a_in;
   logic [VW-1:0]       root_b_ff, root_b_in;
   logic                pend_vld_ff, pend_vld_in;
   logic [KW-1:0]       pend_ff, pend_in;
   logic                out_vld_ff, out_vld_in;
   logic [KW-1:0]       out_key_ff, out_key_in;
   logic                out_empty_ff, out_empty_in;
   logic                out_last_ff, out_last_in;
   logic [DROP_W-1:0]   out_drop_ff, out_drop_in;

   logic          edge_wr_en;
   logic [KW-1:0] edge_wr_data;
   logic [KW-1:0] edge_rd_data;
   logic          link_wr_en;
   logic [VW-1:0] link_wr_addr;
   logic [VW-1:0] link_wr_data;
   logic [VW-1:0] link_rd_data;

   logic req_fire, edge_ok, out_free, scan_done, cand;
   logic [CW-1:0] limit;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !out_vld_ff || rsp_ready;

   assign limit = (CW'(vcount_ff) < CW'(MAX_VERTICES)) ? CW'(vcount_ff) : CW'(MAX_VERTICES);
   assign edge_ok = (total_ff < (EW + 1)'(MAX_EDGES))
                    && (CW'(req_from_vertex) < limit) && (CW'(req_to_vertex) < limit);

   // The weight is stored with its sign bit flipped so that one unsigned compare orders keys.
   assign edge_wr_data = {~req_edge_weight[WEIGHT_W-1], req_edge_weight[WEIGHT_W-2:0],
                          req_from_vertex, req_to_vertex};
   assign edge_wr_en = req_fire && (req_kind != 1'(KIND_RUN)) && edge_ok;

   assign scan_done = (state_ff == ST_SCAN) && (scan_idx_ff == total_ff) && !rd_vld_ff;
   assign cand = rd_vld_ff && (!have_prev_ff || edge_rd_data > prev_ff)
                 && (!found_ff || edge_rd_data < best_ff);

   assign link_wr_en   = (state_ff == ST_INIT)
                         || ((state_ff == ST_DECIDE) && (root_a_ff != root_b_ff));
   assign link_wr_addr = (state_ff == ST_INIT) ? init_idx_ff : root_a_ff;
   assign link_wr_data = (state_ff == ST_INIT) ? init_idx_ff : root_b_ff;

   kmst_ram #(.WIDTH(KW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock  (clock),
      .wr_en  (edge_wr_en),
      .wr_addr(total_ff[EW-1:0]),
      .wr_data(edge_wr_data),
      .rd_addr(scan_idx_ff[EW-1:0]),
      .rd_data(edge_rd_data)
   );

   kmst_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_link_ram (
      .clock  (clock),
      .wr_en  (link_wr_en),
      .wr_addr(link_wr_addr),
      .wr_data(link_wr_data),
      .rd_addr(walk_v_ff),
      .rd_data(link_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind == 1'(KIND_RUN))) state_in = ST_INIT;
         end
         ST_INIT: begin
            if (init_idx_ff == VW'(MAX_VERTICES - 1)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = found_ff ? ST_WALK_RD : ST_FINAL;
         end
         ST_WALK_RD: state_in = ST_WALK_CHK;
         ST_WALK_CHK: begin
            if (link_rd_data == walk_v_ff && side_ff) state_in = ST_DECIDE;
            else state_in = ST_WALK_RD;
         end
         ST_DECIDE: state_in = (root_a_ff != root_b_ff) ? ST_PUSH : ST_SCAN;
         ST_PUSH: begin
            if (!pend_vld_ff || out_free) state_in = ST_SCAN;
         end
         ST_FINAL: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      vcount_in    = csr_write_enable ? csr_write_data : vcount_ff;
      total_in     = total_ff;
      drop_in      = drop_ff;
      init_idx_in  = init_idx_ff;
      scan_idx_in  = scan_idx_ff;
      rd_vld_in    = 1'b0;
      found_in     = found_ff;
      best_in      = best_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      walk_v_in    = walk_v_ff;
      side_in      = side_ff;
      root_a_in    = root_a_ff;
      root_b_in    = root_b_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      out_vld_in   = out_vld_ff && !rsp_ready;
      out_key_in   = out_key_ff;
      out_empty_in = out_empty_ff;
      out_last_in  = out_last_ff;
      out_drop_in  = out_drop_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_kind == 1'(KIND_RUN)) begin
                  init_idx_in  = '0;
                  scan_idx_in  = '0;
                  found_in     = 1'b0;
                  have_prev_in = 1'b0;
                  pend_vld_in  = 1'b0;
               end else if (edge_ok) begin
                  total_in = total_ff + 1'b1;
               end else if (drop_ff != '1) begin
                  drop_in = drop_ff + 1'b1;
               end
            end
         end
         ST_INIT: init_idx_in = init_idx_ff + 1'b1;
         ST_SCAN: begin
            if (scan_idx_ff != total_ff) begin
               scan_idx_in = scan_idx_ff + 1'b1;
               rd_vld_in   = 1'b1;
            end
            if (cand) begin
               found_in = 1'b1;
               best_in  = edge_rd_data;
            end
            if (scan_done && found_ff) begin
               prev_in      = best_ff;
               have_prev_in = 1'b1;
               walk_v_in    = best_ff[2*VW-1:VW];
               side_in      = 1'b0;
            end
         end
         ST_WALK_RD: ;
         ST_WALK_CHK: begin
            if (link_rd_data != walk_v_ff) begin
               walk_v_in = link_rd_data;
            end else if (!side_ff) begin
               root_a_in = walk_v_ff;
               walk_v_in = best_ff[VW-1:0];
               side_in   = 1'b1;
            end else begin
               root_b_in = walk_v_ff;
            end
         end
         ST_DECIDE: begin
            if (root_a_ff == root_b_ff) begin
               scan_idx_in = '0;
               found_in    = 1'b0;
            end
         end
         ST_PUSH: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  out_vld_in   = 1'b1;
                  out_key_in   = pend_ff;
                  out_empty_in = 1'b0;
                  out_last_in  = 1'b0;
                  out_drop_in  = drop_ff;
               end
               pend_vld_in = 1'b1;
               pend_in     = best_ff;
               scan_idx_in = '0;
               found_in    = 1'b0;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               out_vld_in   = 1'b1;
               out_key_in   = pend_vld_ff ? pend_ff : {1'b1, (KW - 1)'(0)};
               out_empty_in = !pend_vld_ff;
               out_last_in  = 1'b1;
               out_drop_in  = drop_ff;
               pend_vld_in  = 1'b0;
               total_in     = '0;
               drop_in      = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         vcount_ff   <= VCOUNT_W'(32);
         total_ff    <= '0;
         drop_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         vcount_ff   <= vcount_in;
         total_ff    <= total_in;
         drop_ff     <= drop_in;
         rd_vld_ff   <= rd_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      init_idx_ff  <= init_idx_in;
      scan_idx_ff  <= scan_idx_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      have_prev_ff <= have_prev_in;
      prev_ff      <= prev_in;
      walk_v_ff    <= walk_v_in;
      side_ff      <= side_in;
      root_a_ff    <= root_a_in;
      root_b_ff    <= root_b_in;
      pend_ff      <= pend_in;
      out_key_ff   <= out_key_in;
      out_empty_ff <= out_empty_in;
      out_last_ff  <= out_last_in;
      out_drop_ff  <= out_drop_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_tree_weight   = {~out_key_ff[KW-1], out_key_ff[KW-2:2*VW]};
   assign rsp_tree_from     = out_key_ff[2*VW-1:VW];
   assign rsp_tree_to       = out_key_ff[VW-1:0];
   assign rsp_is_empty      = out_empty_ff;
   assign rsp_is_last       = out_last_ff;
   assign rsp_dropped_count = out_drop_ff;

endmodule
`default_nettype wire

// ===== tb/kmst_checker.sv =====
// Checker for the spanning tree block: watches the channels, predicts each tree edge, compares.
`timescale 1ns / 100ps
module kmst_checker #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [4:0]  req_from_vertex,
   input  logic [4:0]  req_to_vertex,
   input  logic signed [15:0] req_edge_weight,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [4:0]  rsp_tree_from,
   input  logic [4:0]  rsp_tree_to,
   input  logic signed [15:0] rsp_tree_weight,
   input  logic        rsp_is_empty,
   input  logic        rsp_is_last,
   input  logic [5:0]  rsp_dropped_count,
   output int          fail_count,
   output int          pending,
   output int          run_total,
   output int          tree_edge_total
);

   typedef struct packed {
      logic signed [15:0] wt;
      logic [4:0]         from_v;
      logic [4:0]         to_v;
   } graph_edge_type;

   typedef struct packed {
      logic [4:0]         from_v;
      logic [4:0]         to_v;
      logic signed [15:0] wt;
      logic               empty;
      logic               last;
      logic [5:0]         drops;
   } tree_edge_type;

   graph_edge_type loaded_edges[MAX_EDGES];
   int             loaded_total;
   logic [4:0]     parent[MAX_VERTICES];
   logic [5:0]     drop_tally;
   logic [5:0]     vertex_limit;
   tree_edge_type  tree_expect_q[$];

   function automatic bit edge_less(graph_edge_type a, graph_edge_type b);
      if (a.wt != b.wt) return a.wt < b.wt;
      if (a.from_v != b.from_v) return a.from_v < b.from_v;
      return a.to_v < b.to_v;
   endfunction

   function automatic int find_root(int v);
      int steps;
      steps = 0;
      while (steps < MAX_VERTICES && parent[v] != v) begin
         v = parent[v];
         steps++;
      end
      return v;
   endfunction

   task automatic load_edge(logic [4:0] f, logic [4:0] t, logic signed [15:0] w);
      int lim;
      lim = (vertex_limit < MAX_VERTICES) ? vertex_limit : MAX_VERTICES;
      if (loaded_total >= MAX_EDGES || f >= lim || t >= lim) begin
         if (drop_tally != 6'd63) drop_tally++;
      end else begin
         loaded_edges[loaded_total] = '{wt: w, from_v: f, to_v: t};
         loaded_total++;
      end
   endtask

   task automatic build_tree();
      graph_edge_type ordered[MAX_EDGES];
      graph_edge_type e;
      tree_edge_type  r;
      int j, ra, rb, emitted;
      emitted = 0;
      for (int v = 0; v < MAX_VERTICES; v++) parent[v] = 5'(v);
      for (int i = 0; i < loaded_total; i++) begin
         e = loaded_edges[i];
         j = i;
         while (j > 0 && edge_less(e, ordered[j-1])) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = e;
      end
      for (int i = 0; i < loaded_total && emitted < 31; i++) begin
         ra = find_root(ordered[i].from_v);
         rb = find_root(ordered[i].to_v);
         if (ra != rb) begin
            parent[ra] = 5'(rb);
            r = '{from_v: ordered[i].from_v, to_v: ordered[i].to_v, wt: ordered[i].wt,
                  empty: 1'b0, last: 1'b0, drops: drop_tally};
            tree_expect_q.insert(tree_expect_q.size(), r);
            emitted++;
         end
      end
      if (emitted == 0) begin
         r = '{from_v: '0, to_v: '0, wt: '0, empty: 1'b1, last: 1'b1, drops: drop_tally};
         tree_expect_q.insert(tree_expect_q.size(), r);
      end else begin
         tree_expect_q[tree_expect_q.size()-1].last = 1'b1;
      end
      loaded_total = 0;
      drop_tally = '0;
   endtask

   always @(posedge clock) begin
      tree_edge_type want;
      if (reset) begin
         loaded_total = 0;
         drop_tally = '0;
         vertex_limit = 6'd32;
         tree_expect_q.delete();
         fail_count <= 0;
         run_total <= 0;
         tree_edge_total <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_kind) begin
               build_tree();
               run_total <= run_total + 1;
            end else begin
               load_edge(req_from_vertex, req_to_vertex, req_edge_weight);
            end
         end
         // The block sees a new vertex count only from the next cycle on.
         if (csr_write_enable) vertex_limit = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            tree_edge_total <= tree_edge_total + 1;
            if (tree_expect_q.size() == 0) begin
               $error("unexpected result: from %0d to %0d weight %0d", rsp_tree_from,
                      rsp_tree_to, rsp_tree_weight);
               fail_count <= fail_count + 1;
            end else begin
               want = tree_expect_q.pop_front();
               if (rsp_tree_from !== want.from_v || rsp_tree_to !== want.to_v ||
                   rsp_tree_weight !== want.wt || rsp_is_empty !== want.empty ||
                   rsp_is_last !== want.last || rsp_dropped_count !== want.drops) begin
                  fail_count <= fail_count + 1;
                  if (rsp_tree_from !== want.from_v)
                     $error("tree_from: expected %0d, got %0d", want.from_v, rsp_tree_from);
                  if (rsp_tree_to !== want.to_v)
                     $error("tree_to: expected %0d, got %0d", want.to_v, rsp_tree_to);
                  if (rsp_tree_weight !== want.wt)
                     $error("tree_weight: expected %0d, got %0d", want.wt, rsp_tree_weight);
                  if (rsp_is_empty !== want.empty)
                     $error("is_empty: expected %0d, got %0d", want.empty, rsp_is_empty);
                  if (rsp_is_last !== want.last)
                     $error("is_last: expected %0d, got %0d", want.last, rsp_is_last);
                  if (rsp_dropped_count !== want.drops)
                     $error("dropped_count: expected %0d, got %0d", want.drops,
                            rsp_dropped_count);
               end
            end
         end
      end
      pending <= tree_expect_q.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the spanning tree testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps
module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [5:0]  csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [4:0]  req_from_vertex = '0;
   logic [4:0]  req_to_vertex = '0;
   logic signed [15:0] req_edge_weight = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_tree_from;
   logic [4:0]  rsp_tree_to;
   logic signed [15:0] rsp_tree_weight;
   logic        rsp_is_empty;
   logic        rsp_is_last;
   logic [5:0]  rsp_dropped_count;
   int          fail_count, pending, run_total, tree_edge_total;
   int          burst_left = 0;
   int          items_sent = 0;
   logic [5:0]  cur_vcount = 6'd32;

   always #10 clock = ~clock;

   kruskal_minimum_spanning_tree_top #(.MAX_VERTICES(32), .MAX_EDGES(64)) i_dut (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_ready, .req_kind, .req_from_vertex, .req_to_vertex, .req_edge_weight,
      .rsp_valid, .rsp_ready, .rsp_tree_from, .rsp_tree_to, .rsp_tree_weight,
      .rsp_is_empty, .rsp_is_last, .rsp_dropped_count
   );

   kmst_checker #(.MAX_VERTICES(32), .MAX_EDGES(64)) i_checker (.*);

   // The receiver switches between always ready, coin-flip and mostly stalled.
   int stall_mode = 0;
   int mode_cycles = 0;
   always @(posedge clock) begin
      if (mode_cycles == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_cycles <= $urandom_range(20, 300);
      end else begin
         mode_cycles <= mode_cycles - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_item(logic kind, logic [4:0] f, logic [4:0] t, logic signed [15:0] w);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_from_vertex <= f;
      req_to_vertex <= t;
      req_edge_weight <= w;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   // Waits until every tree edge has come out and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_vcount(logic [5:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      cur_vcount = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_edge();
      int lim;
      logic [4:0] f, t;
      logic signed [15:0] w;
      lim = (cur_vcount > 32) ? 32 : cur_vcount;
      if (lim == 0 || $urandom_range(0, 9) == 0) begin
         f = 5'($urandom);
         t = 5'($urandom);
      end else begin
         f = 5'($urandom_range(0, lim - 1));
         t = 5'($urandom_range(0, lim - 1));
      end
      // Narrow weights make ties that exercise the secondary sort keys.
      if ($urandom_range(0, 1)) w = 16'($signed($urandom_range(0, 6)) - 3);
      else w = 16'($urandom);
      send_item(1'b0, f, t, w);
   endtask

   task automatic run_tree();
      send_item(1'b1, 5'($urandom), 5'($urandom), 16'($urandom));
   endtask

   initial begin
      int phase;
      logic [5:0] vc;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme weights and vertices, a duplicate and a self loop.
      send_item(1'b0, 5'd31, 5'd0, 16'sh7fff);
      send_item(1'b0, 5'd0, 5'd31, -16'sd32768);
      send_item(1'b0, 5'd3, 5'd3, 16'sd0);
      send_item(1'b0, 5'd1, 5'd2, 16'sd5);
      send_item(1'b0, 5'd1, 5'd2, 16'sd5);
      send_item(1'b0, 5'd2, 5'd31, 16'sd5);
      send_item(1'b0, 5'd31, 5'd1, 16'sd5);
      run_tree();
      // A run with nothing loaded.
      run_tree();
      write_vcount(6'd4);
      send_item(1'b0, 5'd4, 5'd1, 16'sd7);
      send_item(1'b0, 5'd3, 5'd3, -16'sd1);
      run_tree();
      write_vcount(6'd1);
      send_item(1'b0, 5'd0, 5'd0, 16'sd9);
      send_item(1'b0, 5'd0, 5'd1, 16'sd9);
      run_tree();

      // Random phases; one of them fills the edge table and another saturates the drop tally.
      phase = 0;
      while (items_sent < 270) begin
         case (phase % 6)
            0: vc = 6'd32;
            1: vc = 6'd63;
            2: vc = 6'($urandom_range(2, 31));
            3: vc = 6'd1;
            default: vc = 6'($urandom_range(2, 32));
         endcase
         if (phase == 3) vc = 6'd0;
         write_vcount(vc);
         if (phase == 1 || phase == 3) begin
            repeat (70) random_edge();
         end else begin
            repeat ($urandom_range(0, 16)) random_edge();
         end
         run_tree();
         phase++;
      end

      write_vcount(6'd32);
      drain();
      $display("Covered %0d items in %0d runs, %0d tree results checked.", items_sent,
               run_total, tree_edge_total);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/kmst_pkg.sv
src/kmst_ram.sv
src/kruskal_minimum_spanning_tree_top.sv
tb/kmst_checker.sv
tb/testbench.sv
